// ----- design/kmsr_pkg.sv -----
// Package for the key matrix scan report block.
// Widths, reset values and the types shared between front end, queue and back end.
// No dependencies.
package kmsr_pkg;

   localparam int KEY_MASK_W      = 6;
   localparam int CODE_W          = 8;
   localparam int CODE_FIELDS     = 6;
   localparam int COUNT_W         = 3;
   localparam int DEF_KEY_ROWS    = 2;
   localparam int DEF_KEY_COLUMNS = 3;
   localparam int DEF_REPORT_SLOTS = 6;
   localparam int QUEUE_DEPTH     = 2;
   localparam int QUEUE_PTR_W     = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W     = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CODE_W-1:0] CODE_BASE_RESET = 8'd4;

   // one classified scan, handed from front end to back end
   typedef struct packed {
      logic [KEY_MASK_W-1:0] held;
      logic [KEY_MASK_W-1:0] presses;
      logic [KEY_MASK_W-1:0] releases;
   } edge_entry_type;

   typedef struct packed {
      logic not_full;
      logic not_empty;
   } queue_status_type;

endpackage

// ----- design/kmsr_if.sv -----
// Channel interfaces of the key matrix scan report block.
// Depends on kmsr_pkg for field widths.
interface kmsr_req_if
   import kmsr_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [KEY_MASK_W-1:0] key_sample;

   modport source (output valid, output key_sample, input ready);
   modport sink (input valid, input key_sample, output ready);
endinterface

interface kmsr_rsp_if
   import kmsr_pkg::*;
();
   logic                  valid;
   logic                  ready;
   logic [KEY_MASK_W-1:0] held_keys;
   logic [KEY_MASK_W-1:0] new_presses;
   logic [KEY_MASK_W-1:0] releases;
   logic [CODE_W-1:0]     code_0;
   logic [CODE_W-1:0]     code_1;
   logic [CODE_W-1:0]     code_2;
   logic [CODE_W-1:0]     code_3;
   logic [CODE_W-1:0]     code_4;
   logic [CODE_W-1:0]     code_5;
   logic [COUNT_W-1:0]    code_count;
   logic                  rollover;

   modport source (output valid, output held_keys, output new_presses, output releases,
                   output code_0, output code_1, output code_2, output code_3,
                   output code_4, output code_5, output code_count, output rollover,
                   input ready);
   modport sink (input valid, input held_keys, input new_presses, input releases,
                 input code_0, input code_1, input code_2, input code_3,
                 input code_4, input code_5, input code_count, input rollover,
                 output ready);
endinterface

// ----- design/kmsr_front.sv -----
// Front end: takes scans, masks them to the matrix and derives press/release edges.
// Holds the held-key state. Depends on kmsr_pkg and kmsr_req_if.
module kmsr_front
   import kmsr_pkg::*;
#(
   parameter int KEY_ROWS    = DEF_KEY_ROWS,
   parameter int KEY_COLUMNS = DEF_KEY_COLUMNS
) (
   input  logic             clock,
   input  logic             reset,
   kmsr_req_if.sink         req_chan,
   input  queue_status_type q_status,
   output logic             push,
   output edge_entry_type   push_entry
);

   localparam int KEY_COUNT = KEY_ROWS * KEY_COLUMNS;
   localparam int USED_KEYS = (KEY_COUNT > KEY_MASK_W) ? KEY_MASK_W : KEY_COUNT;
   localparam logic [KEY_MASK_W-1:0] KEY_MASK =
      KEY_MASK_W'((64'd1 << USED_KEYS) - 64'd1);

   logic [KEY_MASK_W-1:0] key_state_ff;
   logic [KEY_MASK_W-1:0] key_state_in;
   logic [KEY_MASK_W-1:0] sample;

   assign req_chan.ready = q_status.not_full;
   assign push           = req_chan.valid & q_status.not_full;
   assign sample         = req_chan.key_sample & KEY_MASK;

   assign push_entry.held     = sample;
   assign push_entry.presses  = sample & ~key_state_ff;
   assign push_entry.releases = key_state_ff & ~sample;

   assign key_state_in = push ? sample : key_state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_state_ff <= '0;
      end else begin
         key_state_ff <= key_state_in;
      end
   end

endmodule

// ----- design/kmsr_queue.sv -----
// Two-entry queue between front and back end.
// Depends on kmsr_pkg for the entry type.
module kmsr_queue
   import kmsr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  edge_entry_type   push_entry,
   input  logic             pop,
   output edge_entry_type   pop_entry,
   output queue_status_type q_status
);

   edge_entry_type            store_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]    wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_ff;
   logic [QUEUE_PTR_W-1:0]    rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]    count_ff;
   logic [QUEUE_CNT_W-1:0]    count_in;

   assign q_status.not_full  = (count_ff != QUEUE_CNT_W'(QUEUE_DEPTH));
   assign q_status.not_empty = (count_ff != '0);
   assign pop_entry          = store_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({push, pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         store_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ----- design/kmsr_back.sv -----
// Back end: builds the keyboard report from a queued scan into the output register.
// Depends on kmsr_pkg and kmsr_rsp_if.
module kmsr_back
   import kmsr_pkg::*;
#(
   parameter int REPORT_SLOTS = DEF_REPORT_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [CODE_W-1:0] code_base,
   input  queue_status_type  q_status,
   input  edge_entry_type    pop_entry,
   output logic              pop,
   kmsr_rsp_if.source        rsp_chan
);

   localparam int SLOTS_USED = (REPORT_SLOTS > CODE_FIELDS) ? CODE_FIELDS : REPORT_SLOTS;

   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   logic [CODE_W-1:0]     codes_ff [CODE_FIELDS];
   logic [CODE_W-1:0]     codes_in [CODE_FIELDS];
   logic [COUNT_W-1:0]    filled_in;
   logic [COUNT_W-1:0]    filled_ff;
   logic [COUNT_W-1:0]    held_cnt;
   logic                  rollover_ff;
   edge_entry_type        entry_ff;

   assign pop          = q_status.not_empty & (~rsp_valid_ff | rsp_chan.ready);
   assign rsp_valid_in = pop | (rsp_valid_ff & ~rsp_chan.ready);

   // slots fill in ascending key order
   always_comb begin
      filled_in = '0;
      held_cnt  = '0;
      for (int f = 0; f < CODE_FIELDS; f++) begin
         codes_in[f] = '0;
      end
      for (int i = 0; i < KEY_MASK_W; i++) begin
         if (pop_entry.held[i]) begin
            held_cnt = held_cnt + 1'b1;
            if (filled_in < COUNT_W'(SLOTS_USED)) begin
               codes_in[filled_in] = code_base + CODE_W'(i);
               filled_in = filled_in + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         entry_ff    <= pop_entry;
         codes_ff    <= codes_in;
         filled_ff   <= filled_in;
         rollover_ff <= (held_cnt > COUNT_W'(SLOTS_USED));
      end
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.held_keys   = entry_ff.held;
   assign rsp_chan.new_presses = entry_ff.presses;
   assign rsp_chan.releases    = entry_ff.releases;
   assign rsp_chan.code_0      = codes_ff[0];
   assign rsp_chan.code_1      = codes_ff[1];
   assign rsp_chan.code_2      = codes_ff[2];
   assign rsp_chan.code_3      = codes_ff[3];
   assign rsp_chan.code_4      = codes_ff[4];
   assign rsp_chan.code_5      = codes_ff[5];
   assign rsp_chan.code_count  = filled_ff;
   assign rsp_chan.rollover    = rollover_ff;

endmodule

// ----- design/key_matrix_scan_report.sv -----
// Top level of the key matrix scan report block.
// Depends on kmsr_pkg, kmsr_if, kmsr_front, kmsr_queue and kmsr_back.
//
// Each req_chan transaction carries one full matrix scan (one bit per key).
// Each produces exactly one rsp_chan transaction: the held-key mask, newly
// pressed and released keys, up to six report codes (code base plus key
// index, lowest index first, unused slots 0), the slot count and rollover.
// csr_write_enable/csr_write_data load the code base; write it while idle.
// A scan accepted on req_chan is written into the queue, then popped into the
// output register and offered on rsp_chan from there. Throughput: one scan
// per cycle while rsp_chan does not stall, set by the edge stage in front
// and the report stage behind the two-entry queue.
// When rsp_chan stalls the output register holds, the queue fills and
// req_chan.ready drops once both queue entries are taken; it rises again in
// the cycle after the output register is drained.
// Reset (synchronous) empties queue and output register, clears the held-key
// mask to all released and sets the code base to 4.
module key_matrix_scan_report
   import kmsr_pkg::*;
#(
   parameter int KEY_ROWS     = DEF_KEY_ROWS,
   parameter int KEY_COLUMNS  = DEF_KEY_COLUMNS,
   parameter int REPORT_SLOTS = DEF_REPORT_SLOTS
) (
   input  logic              clock,
   input  logic              reset,
   kmsr_req_if.sink          req_chan,
   kmsr_rsp_if.source        rsp_chan,
   input  logic              csr_write_enable,
   input  logic [CODE_W-1:0] csr_write_data
);

   logic [CODE_W-1:0] code_base_ff;
   logic [CODE_W-1:0] code_base_in;
   queue_status_type  q_status;
   logic              push;
   logic              pop;
   edge_entry_type    push_entry;
   edge_entry_type    pop_entry;

   assign code_base_in = csr_write_enable ? csr_write_data : code_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         code_base_ff <= CODE_BASE_RESET;
      end else begin
         code_base_ff <= code_base_in;
      end
   end

   kmsr_front #(
      .KEY_ROWS    (KEY_ROWS),
      .KEY_COLUMNS (KEY_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_status   (q_status),
      .push       (push),
      .push_entry (push_entry)
   );

   kmsr_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .pop_entry  (pop_entry),
      .q_status   (q_status)
   );

   kmsr_back #(
      .REPORT_SLOTS (REPORT_SLOTS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .code_base (code_base_ff),
      .q_status  (q_status),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

endmodule
